### hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared shorthand for concurrent checks on a clock with async low reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property holds at every edge outside reset.
`define CHK_ALWAYS(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("check failed");

// Antecedent at one edge implies consequent at the next edge.
`define CHK_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("check failed");

`endif

### hw/rtl/deqs_pkg.sv
// ----------------------------------------------------------------------------
// deqs_pkg
// Types and constants shared by the double-ended queue with search.
// ----------------------------------------------------------------------------
package deqs_pkg;

	localparam int DEPTH      = 16;
	localparam int DATA_WIDTH = 32;
	localparam int IDX_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W      = $clog2(DEPTH + 1);

	// Command function codes as they arrive on the bus
	localparam logic [2:0] FN_PUSH_BACK  = 3'd0;
	localparam logic [2:0] FN_PUSH_FRONT = 3'd1;
	localparam logic [2:0] FN_POP_FRONT  = 3'd2;
	localparam logic [2:0] FN_POP_BACK   = 3'd3;
	localparam logic [2:0] FN_PEEK_FRONT = 3'd4;
	localparam logic [2:0] FN_SEARCH     = 3'd5;

	// Response status codes
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;
	localparam logic [1:0] ST_BAD   = 2'd3;

	typedef logic [DATA_WIDTH-1:0] data_t;

	typedef enum logic [2:0] {
		OP_PUSH_BACK,
		OP_PUSH_FRONT,
		OP_POP_FRONT,
		OP_POP_BACK,
		OP_PEEK_FRONT,
		OP_SEARCH,
		OP_NOP
	} op_t;

	typedef struct packed {
		logic [2:0]  func;
		logic [31:0] value;
	} cmd_t;

	typedef struct packed {
		logic [31:0] data_out;
		logic        found;
		logic [1:0]  status;
		logic [4:0]  count;
	} rsp_t;

	// Classified job passed from front to back
	typedef struct packed {
		op_t   op;
		data_t value;
	} job_t;

endpackage

### hw/rtl/deqs_front.sv
// ----------------------------------------------------------------------------
// deqs_front
// Accepts command beats, decodes the function code and buffers the decoded
// jobs in a two-entry queue for the execution side.
// ----------------------------------------------------------------------------
module deqs_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cmd_valid,
	output logic          cmd_stall,
	input  deqs_pkg::cmd_t cmd,
	output logic          job_valid,
	input  logic          job_take,
	output deqs_pkg::job_t job
);
	import deqs_pkg::*;

	job_t       slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] fill_q;
	logic       push;
	logic       pop;
	job_t       decoded;

	always_comb begin
		decoded.value = data_t'(cmd.value);
		case (cmd.func)
			FN_PUSH_BACK:  decoded.op = OP_PUSH_BACK;
			FN_PUSH_FRONT: decoded.op = OP_PUSH_FRONT;
			FN_POP_FRONT:  decoded.op = OP_POP_FRONT;
			FN_POP_BACK:   decoded.op = OP_POP_BACK;
			FN_PEEK_FRONT: decoded.op = OP_PEEK_FRONT;
			FN_SEARCH:     decoded.op = OP_SEARCH;
			default:       decoded.op = OP_NOP;
		endcase
	end

	assign cmd_stall = (fill_q == 2'd2);
	assign push      = cmd_valid && !cmd_stall;
	assign job_valid = (fill_q != 2'd0);
	assign pop       = job_valid && job_take;
	assign job       = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= decoded;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   fill_q <= fill_q + 2'd1;
				2'b01:   fill_q <= fill_q - 2'd1;
				default: fill_q <= fill_q;
			endcase
		end
	end

endmodule

### hw/rtl/deqs_back.sv
// ----------------------------------------------------------------------------
// deqs_back
// Executes decoded jobs on the ring memory: pushes, pops, peeks and a
// one-entry-per-cycle search, and holds the response beat in a register.
// ----------------------------------------------------------------------------
module deqs_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           job_valid,
	output logic           job_take,
	input  deqs_pkg::job_t job,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output deqs_pkg::rsp_t rsp
);
	import deqs_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE,
		S_READ,
		S_SEARCH
	} state_t;

	state_t             state_q, state_d;
	logic [IDX_W-1:0]   head_q, head_d;
	logic [CNT_W-1:0]   cnt_q, cnt_d;
	logic [IDX_W-1:0]   idx_q, idx_d;
	data_t              key_q, key_d;
	logic               rsp_valid_q;
	rsp_t               rsp_q, res;
	logic               fin;

	data_t              ring [DEPTH];
	data_t              rd_data_q;
	logic               we, re;
	logic [IDX_W-1:0]   waddr, raddr;
	data_t              wdata;

	logic               slot_free;
	logic               is_full, is_empty;
	logic               hit, last;

	// Ring position: sum of two in-range offsets stays below twice the depth
	function automatic logic [IDX_W-1:0] wrap(input logic [IDX_W:0] s);
		logic [IDX_W:0] r;
		r = (s >= (IDX_W+1)'(DEPTH)) ? s - (IDX_W+1)'(DEPTH) : s;
		return r[IDX_W-1:0];
	endfunction

	assign slot_free = !rsp_valid_q || !rsp_stall;
	assign job_take  = (state_q == S_IDLE) && job_valid && slot_free;
	assign is_full   = (cnt_q == CNT_W'(DEPTH));
	assign is_empty  = (cnt_q == '0);
	assign hit       = (rd_data_q == key_q);
	assign last      = (CNT_W'({1'b0, idx_q}) + CNT_W'(1) == cnt_q);

	always_comb begin
		state_d = state_q;
		head_d  = head_q;
		cnt_d   = cnt_q;
		idx_d   = idx_q;
		key_d   = key_q;
		we      = 1'b0;
		waddr   = head_q;
		wdata   = job.value;
		re      = 1'b0;
		raddr   = head_q;
		fin     = 1'b0;
		res     = '0;
		case (state_q)
			S_IDLE: begin
				if (job_take) begin
					case (job.op)
						OP_PUSH_BACK: begin
							fin = 1'b1;
							if (is_full) begin
								res.status = ST_FULL;
							end else begin
								we    = 1'b1;
								waddr = wrap({1'b0, head_q} + (IDX_W+1)'(cnt_q));
								cnt_d = cnt_q + CNT_W'(1);
							end
						end
						OP_PUSH_FRONT: begin
							fin = 1'b1;
							if (is_full) begin
								res.status = ST_FULL;
							end else begin
								head_d = wrap({1'b0, head_q} + (IDX_W+1)'(DEPTH - 1));
								we     = 1'b1;
								waddr  = head_d;
								cnt_d  = cnt_q + CNT_W'(1);
							end
						end
						OP_POP_FRONT: begin
							if (is_empty) begin
								fin        = 1'b1;
								res.status = ST_EMPTY;
							end else begin
								re      = 1'b1;
								raddr   = head_q;
								head_d  = wrap({1'b0, head_q} + (IDX_W+1)'(1));
								cnt_d   = cnt_q - CNT_W'(1);
								state_d = S_READ;
							end
						end
						OP_POP_BACK: begin
							if (is_empty) begin
								fin        = 1'b1;
								res.status = ST_EMPTY;
							end else begin
								cnt_d   = cnt_q - CNT_W'(1);
								re      = 1'b1;
								raddr   = wrap({1'b0, head_q} + (IDX_W+1)'(cnt_d));
								state_d = S_READ;
							end
						end
						OP_PEEK_FRONT: begin
							if (is_empty) begin
								fin        = 1'b1;
								res.status = ST_EMPTY;
							end else begin
								re      = 1'b1;
								raddr   = head_q;
								state_d = S_READ;
							end
						end
						OP_SEARCH: begin
							if (is_empty) begin
								fin = 1'b1;
							end else begin
								re      = 1'b1;
								raddr   = head_q;
								idx_d   = '0;
								key_d   = job.value;
								state_d = S_SEARCH;
							end
						end
						default: begin
							fin = 1'b1;
						end
					endcase
				end
			end
			S_READ: begin
				res.data_out = 32'(rd_data_q);
				if (slot_free) begin
					fin     = 1'b1;
					state_d = S_IDLE;
				end
			end
			S_SEARCH: begin
				res.found = hit;
				if (hit || last) begin
					if (slot_free) begin
						fin     = 1'b1;
						state_d = S_IDLE;
					end
				end else begin
					// advance to the next stored entry
					idx_d = idx_q + IDX_W'(1);
					re    = 1'b1;
					raddr = wrap({1'b0, head_q} + {1'b0, idx_d});
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
		res.count = 5'(cnt_d);
	end

	always_ff @(posedge clk) begin
		if (we) begin
			ring[waddr] <= wdata;
		end
		if (re) begin
			rd_data_q <= ring[raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			head_q      <= '0;
			cnt_q       <= '0;
			idx_q       <= '0;
			key_q       <= '0;
			rsp_valid_q <= 1'b0;
			rsp_q       <= '0;
		end else begin
			state_q <= state_d;
			head_q  <= head_d;
			cnt_q   <= cnt_d;
			idx_q   <= idx_d;
			key_q   <= key_d;
			if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			if (fin) begin
				rsp_valid_q <= 1'b1;
				rsp_q       <= res;
			end
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

### hw/rtl/double_ended_queue_with_search.sv
// ----------------------------------------------------------------------------
// double_ended_queue_with_search
// Bounded deque of words in a ring memory with push/pop at both ends, peek
// and search by value; one response beat per command beat.
// ----------------------------------------------------------------------------
// A two-entry command queue lets new commands in while the executor works or
// a response waits. Once the executor picks a command, a push (or a refused
// push, pop or peek, or an unused code) registers its response beat for the
// next cycle; a pop or peek first does a registered read of the single-port
// ring memory. A search reads one stored entry per cycle through that same
// port and stops at the first match or at the last stored entry. A search of
// an empty queue answers without reading the ring.
// Responses come in command order.
module double_ended_queue_with_search (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cmd_valid,
	output logic           cmd_stall,
	input  deqs_pkg::cmd_t cmd,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output deqs_pkg::rsp_t rsp
);
	import deqs_pkg::*;

	logic job_valid;
	logic job_take;
	job_t job;

	deqs_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd       (cmd),
		.job_valid (job_valid),
		.job_take  (job_take),
		.job       (job)
	);

	deqs_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (job_valid),
		.job_take  (job_take),
		.job       (job),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

endmodule

### hw/rtl/deqs_checker.sv
// ----------------------------------------------------------------------------
// deqs_checker
// Port-level checks on the deque response channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module deqs_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           cmd_valid,
	input logic           cmd_stall,
	input deqs_pkg::cmd_t cmd,
	input logic           rsp_valid,
	input logic           rsp_stall,
	input deqs_pkg::rsp_t rsp
);
	import deqs_pkg::*;

	logic cmd_beat;

	assign cmd_beat = cmd_valid && !cmd_stall && (cmd.func != FN_SEARCH);

	// a stalled response beat stays offered
	`CHK_NEXT(a_rsp_hold, clk, arst_n, rsp_valid && rsp_stall, rsp_valid)

	`CHK_ALWAYS(a_status_code, clk, arst_n, !rsp_valid || (rsp.status != ST_BAD))

	`CHK_ALWAYS(a_count_range, clk, arst_n, !rsp_valid || (rsp.count <= 5'(DEPTH)))

	// a hit is only ever reported with ok status and no data word
	`CHK_ALWAYS(a_found_clean, clk, arst_n,
		!rsp_valid || !rsp.found || ((rsp.status == ST_OK) && (rsp.data_out == '0)))

	// a refused push leaves the ring full, unless a non-search command beat is accepted in the same cycle
	`CHK_ALWAYS(a_full_count, clk, arst_n,
		!rsp_valid || (rsp.status != ST_FULL) || (rsp.count == 5'(DEPTH)) || cmd_beat)

endmodule

bind double_ended_queue_with_search deqs_checker u_deqs_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.cmd_valid (cmd_valid),
	.cmd_stall (cmd_stall),
	.cmd       (cmd),
	.rsp_valid (rsp_valid),
	.rsp_stall (rsp_stall),
	.rsp       (rsp)
);

### tb/double_ended_queue_with_search_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// double_ended_queue_with_search_tb
// Drives command beats into the deque and checks every response beat against
// a cycle-free model of the ring. The run covers edge cases first, then biased
// random traffic that swings between full and empty, under several idle mixes.
// ----------------------------------------------------------------------------
module double_ended_queue_with_search_tb;
	import deqs_pkg::*;

	localparam int CLK_HALF    = 4;
	localparam int CYCLE_LIMIT = 250000;
	localparam int DRAIN_SLACK = DEPTH + 4;
	localparam int MAX_REPORTS = 10;

	// Codes that the block must treat as no operation
	localparam logic [2:0] FN_SPARE_6 = 3'd6;
	localparam logic [2:0] FN_SPARE_7 = 3'd7;

	logic clk;
	logic arst_n;
	logic cmd_valid;
	logic cmd_stall;
	cmd_t cmd;
	logic rsp_valid;
	logic rsp_stall;
	rsp_t rsp;

	// Model of the ring contents
	data_t            ring_mem [DEPTH];
	logic [IDX_W-1:0] ring_head;
	logic [CNT_W-1:0] ring_fill;

	rsp_t        expected_rsps [$];
	int unsigned mismatch_count;
	int unsigned rsp_count;
	int unsigned cycle_count;
	int unsigned send_idle_pct;
	int unsigned rsp_stall_pct;
	bit          filling;

	double_ended_queue_with_search u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd       (cmd),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	initial begin
		clk = 1'b0;
		forever #CLK_HALF clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("double_ended_queue_with_search regression: fail");
			$finish;
		end
	end

	// Receiver back-pressure, redrawn every cycle
	initial begin
		rsp_stall = 1'b0;
		forever begin
			@(negedge clk);
			rsp_stall = ($urandom_range(99) < rsp_stall_pct);
		end
	end

	function automatic rsp_t predict_deque_rsp(input cmd_t c);
		rsp_t             r;
		logic [IDX_W-1:0] pos;
		r = '0;
		case (c.func)
			FN_PUSH_BACK: begin
				if (ring_fill == DEPTH) begin
					r.status = ST_FULL;
				end else begin
					pos = ring_head + ring_fill[IDX_W-1:0];
					ring_mem[pos] = c.value;
					ring_fill = ring_fill + 1'b1;
				end
			end
			FN_PUSH_FRONT: begin
				if (ring_fill == DEPTH) begin
					r.status = ST_FULL;
				end else begin
					ring_head = ring_head - 1'b1;
					ring_mem[ring_head] = c.value;
					ring_fill = ring_fill + 1'b1;
				end
			end
			FN_POP_FRONT: begin
				if (ring_fill == 0) begin
					r.status = ST_EMPTY;
				end else begin
					r.data_out = ring_mem[ring_head];
					ring_head = ring_head + 1'b1;
					ring_fill = ring_fill - 1'b1;
				end
			end
			FN_POP_BACK: begin
				if (ring_fill == 0) begin
					r.status = ST_EMPTY;
				end else begin
					// a full ring has fill bits [3:0] at zero, so this wraps to head - 1
					pos = ring_head + ring_fill[IDX_W-1:0] - 1'b1;
					r.data_out = ring_mem[pos];
					ring_fill = ring_fill - 1'b1;
				end
			end
			FN_PEEK_FRONT: begin
				if (ring_fill == 0)
					r.status = ST_EMPTY;
				else
					r.data_out = ring_mem[ring_head];
			end
			FN_SEARCH: begin
				for (int i = 0; i < ring_fill; i++) begin
					pos = ring_head + i[IDX_W-1:0];
					if (ring_mem[pos] == c.value) begin
						r.found = 1'b1;
						break;
					end
				end
			end
			default: begin
			end
		endcase
		r.count = ring_fill;
		return r;
	endfunction

	always @(posedge clk) begin
		rsp_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			rsp_count++;
			if (expected_rsps.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= MAX_REPORTS)
					$display("rsp %0d: unexpected beat data=%h found=%b status=%0d count=%0d",
						rsp_count, rsp.data_out, rsp.found, rsp.status, rsp.count);
			end else begin
				want = expected_rsps.pop_front();
				if (rsp.data_out !== want.data_out || rsp.found !== want.found ||
						rsp.status !== want.status || rsp.count !== want.count) begin
					mismatch_count++;
					if (mismatch_count <= MAX_REPORTS)
						$display({"rsp %0d: exp data=%h found=%b status=%0d count=%0d,",
							" got data=%h found=%b status=%0d count=%0d"}, rsp_count,
							want.data_out, want.found, want.status, want.count,
							rsp.data_out, rsp.found, rsp.status, rsp.count);
				end
			end
		end
	end

	// Present one beat, hold it through stalls, then predict its response
	task automatic send_cmd(input logic [2:0] func, input logic [31:0] value);
		cmd_t c;
		c.func  = func;
		c.value = value;
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			cmd_valid = 1'b0;
			@(negedge clk);
		end
		cmd_valid = 1'b1;
		cmd       = c;
		do @(posedge clk); while (cmd_stall);
		expected_rsps.push_back(predict_deque_rsp(c));
	endtask

	// Hold off new beats until every response is back
	task automatic wait_drained();
		@(negedge clk);
		cmd_valid = 1'b0;
		while (expected_rsps.size() != 0)
			@(posedge clk);
		repeat (DRAIN_SLACK) @(posedge clk);
	endtask

	function automatic logic [31:0] pick_value();
		logic [IDX_W-1:0] pos;
		int unsigned      sel;
		sel = $urandom_range(9);
		if (sel == 0)
			return '0;
		if (sel == 1)
			return '1;
		if (sel <= 4 && ring_fill != 0) begin
			// reuse a stored word so searches hit at varied depths
			pos = ring_head + IDX_W'($urandom_range(ring_fill - 1));
			return ring_mem[pos];
		end
		if (sel == 5)
			return 32'h1 << $urandom_range(31);
		return $urandom;
	endfunction

	function automatic logic [2:0] pick_func();
		int unsigned sel;
		int unsigned push_w;
		int unsigned pop_w;
		if (filling && ring_fill == DEPTH && $urandom_range(3) == 0)
			filling = 1'b0;
		else if (!filling && ring_fill == 0 && $urandom_range(3) == 0)
			filling = 1'b1;
		push_w = filling ? 56 : 20;
		pop_w  = filling ? 20 : 56;
		sel = $urandom_range(99);
		if (sel < 4)
			return $urandom_range(1) ? FN_SPARE_7 : FN_SPARE_6;
		if (sel < 4 + push_w)
			return $urandom_range(1) ? FN_PUSH_FRONT : FN_PUSH_BACK;
		if (sel < 4 + push_w + pop_w)
			return $urandom_range(1) ? FN_POP_BACK : FN_POP_FRONT;
		if (sel < 92)
			return FN_PEEK_FRONT;
		return FN_SEARCH;
	endfunction

	task automatic run_random(input int unsigned n_beats);
		logic [2:0] func;
		for (int unsigned k = 0; k < n_beats; k++) begin
			func = pick_func();
			send_cmd(func, pick_value());
		end
	endtask

	task automatic test_edge_cases();
		send_idle_pct = 0;
		rsp_stall_pct = 0;
		send_cmd(FN_POP_FRONT, 32'h0);
		send_cmd(FN_POP_BACK, 32'hFFFF_FFFF);
		send_cmd(FN_PEEK_FRONT, 32'h0);
		send_cmd(FN_SEARCH, 32'h0);
		send_cmd(FN_SPARE_6, 32'hFFFF_FFFF);
		send_cmd(FN_SPARE_7, 32'h0);
		send_cmd(FN_PUSH_BACK, 32'h0);
		// head wraps below zero here
		send_cmd(FN_PUSH_FRONT, 32'hFFFF_FFFF);
		send_cmd(FN_PEEK_FRONT, 32'h0);
		send_cmd(FN_SEARCH, 32'hFFFF_FFFF);
		send_cmd(FN_SEARCH, 32'h0);
		send_cmd(FN_SEARCH, 32'h0000_0001);
		send_cmd(FN_PUSH_BACK, 32'h8000_0001);
		send_cmd(FN_POP_BACK, 32'h0);
		send_cmd(FN_POP_FRONT, 32'h0);
		send_cmd(FN_POP_FRONT, 32'h0);
		send_cmd(FN_POP_BACK, 32'h0);
		wait_drained();
	endtask

	task automatic test_back_to_back();
		send_idle_pct = 0;
		rsp_stall_pct = 0;
		run_random(256);
		wait_drained();
	endtask

	task automatic test_sender_gaps();
		send_idle_pct = 68;
		rsp_stall_pct = 0;
		run_random(256);
		wait_drained();
	endtask

	task automatic test_receiver_stalls();
		send_idle_pct = 0;
		rsp_stall_pct = 68;
		run_random(256);
		wait_drained();
	endtask

	task automatic test_both_idle();
		send_idle_pct = 20;
		rsp_stall_pct = 20;
		run_random(256);
		wait_drained();
	endtask

	initial begin
		arst_n         = 1'b0;
		cmd_valid      = 1'b0;
		cmd            = '0;
		ring_head      = '0;
		ring_fill      = '0;
		mismatch_count = 0;
		rsp_count      = 0;
		cycle_count    = 0;
		send_idle_pct  = 0;
		rsp_stall_pct  = 0;
		filling        = 1'b1;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_edge_cases();
		test_back_to_back();
		test_sender_gaps();
		test_receiver_stalls();
		test_both_idle();

		if (mismatch_count == 0 && expected_rsps.size() == 0)
			$display("double_ended_queue_with_search regression: pass");
		else
			$display("double_ended_queue_with_search regression: fail");
		$finish;
	end

endmodule

### filelist.f
+incdir+hw/rtl
hw/rtl/deqs_pkg.sv
hw/rtl/deqs_front.sv
hw/rtl/deqs_back.sv
hw/rtl/double_ended_queue_with_search.sv
hw/rtl/deqs_checker.sv
tb/double_ended_queue_with_search_tb.sv
